[src/lts_pkg.sv]
// lts_pkg: types, codes and constants shared by the lexical token scanner files
// depends on nothing; imported by lts_scan, the top level and the checker
package lts_pkg;

  // default sizes of the identifier buffer and the number accumulator
  localparam int unsigned IDENT_CHARS_DEF  = 7;
  localparam int unsigned NUMBER_WIDTH_DEF = 32;

  // fixed field widths of a result item
  localparam int unsigned KIND_W  = 5;
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned TEXT_W  = 56;
  localparam int unsigned LEN_W   = 3;

  // result queue depth: room for two full bytes' worth of tokens
  localparam int unsigned FIFO_DEPTH = 4;

  // token kinds
  typedef enum logic [KIND_W-1:0] {
    TK_END    = 5'd0,
    TK_IF     = 5'd1,
    TK_ELSE   = 5'd2,
    TK_WHILE  = 5'd3,
    TK_DO     = 5'd4,
    TK_FOR    = 5'd5,
    TK_SWITCH = 5'd6,
    TK_IDENT  = 5'd7,
    TK_NUMBER = 5'd8,
    TK_LT     = 5'd9,
    TK_LE     = 5'd10,
    TK_GT     = 5'd11,
    TK_GE     = 5'd12,
    TK_ASSIGN = 5'd13,
    TK_EQ     = 5'd14,
    TK_PLUS   = 5'd15,
    TK_INC    = 5'd16,
    TK_MINUS  = 5'd17,
    TK_DEC    = 5'd18,
    TK_NE     = 5'd19,
    TK_COLON  = 5'd20,
    TK_SEMI   = 5'd21,
    TK_LBRACE = 5'd22,
    TK_RBRACE = 5'd23,
    TK_LPAREN = 5'd24,
    TK_RPAREN = 5'd25,
    TK_PCT    = 5'd26,
    TK_LBRACK = 5'd27,
    TK_STAR   = 5'd28,
    TK_SLASH  = 5'd29,
    TK_ERROR  = 5'd30
  } kind_t;

  // scanner modes
  typedef enum logic [3:0] {
    M_IDLE,
    M_IDENT,
    M_NUMBER,
    M_LT,
    M_GT,
    M_EQ,
    M_PLUS,
    M_MINUS,
    M_BANG,
    M_SLASH,
    M_COMMENT,
    M_CSTAR
  } mode_t;

  // one result item
  typedef struct packed {
    kind_t             kind;
    logic [NUM_W-1:0]  num;
    logic [TEXT_W-1:0] text;
    logic [LEN_W-1:0]  len;
    logic              ovf;
    logic              last;
  } tok_t;

  // tokens produced by one byte, packed from slot 0
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } step_t;

  // keywords, first character in the low byte
  localparam int unsigned KW_NUM = 6;
  localparam logic [63:0] KW_TEXT [KW_NUM] = '{
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6573_6C65,  // else
    64'h0000_0065_6C69_6877,  // while
    64'h0000_0000_0000_6F64,  // do
    64'h0000_0000_0072_6F66,  // for
    64'h0000_6863_7469_7773   // switch
  };
  localparam int unsigned KW_LEN [KW_NUM] = '{2, 4, 5, 2, 3, 6};
  localparam kind_t KW_KIND [KW_NUM] = '{TK_IF, TK_ELSE, TK_WHILE, TK_DO, TK_FOR, TK_SWITCH};

  // token with only a kind
  function automatic tok_t plain_tok(kind_t k);
    tok_t t;
    t      = '0;
    t.kind = k;
    return t;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

endpackage

[src/lts_scan.sv]
// lts_scan: scanner state and the per-byte token logic, up to two tokens a byte
// depends on lts_pkg
module lts_scan
  import lts_pkg::*;
#(
  parameter int unsigned IDENT_CHARS  = IDENT_CHARS_DEF,
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  output step_t      result
);

  localparam int unsigned BUF_W  = 8 * IDENT_CHARS;
  localparam int unsigned CNT_W  = $clog2(IDENT_CHARS + 1);
  localparam int unsigned WIDE_W = NUMBER_WIDTH + 4;

  mode_t                   mode_r, mode_nxt;
  logic [BUF_W-1:0]        buf_r, buf_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [NUMBER_WIDTH-1:0] acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;

  logic                    has_a, has_b;
  tok_t                    tok_a, tok_b;
  logic                    do_start, fresh, add_ch, add_dg;
  logic                    is_pair;
  logic [7:0]              pair_second;
  kind_t                   pair_short, pair_long;
  logic                    kw_hit;
  kind_t                   kw_kind;
  logic [BUF_W-1:0]        base_buf;
  logic [CNT_W-1:0]        base_cnt;
  logic [NUMBER_WIDTH-1:0] base_acc;
  logic                    base_ovf;
  logic [WIDE_W-1:0]       wide;
  logic [63:0]             text_ext;

  // keyword match on the finished identifier
  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = TK_IDENT;
    for (int k = 0; k < KW_NUM; k++) begin
      if (!kw_hit && !ovf_r && cnt_r == CNT_W'(KW_LEN[k]) &&
          buf_r == KW_TEXT[k][BUF_W-1:0]) begin
        kw_hit  = 1'b1;
        kw_kind = KW_KIND[k];
      end
    end
  end

  assign text_ext = 64'(buf_r);

  // token logic and next state
  always_comb begin
    mode_nxt    = mode_r;
    has_a       = 1'b0;
    has_b       = 1'b0;
    tok_a       = plain_tok(TK_END);
    tok_b       = plain_tok(TK_END);
    do_start    = 1'b0;
    fresh       = 1'b0;
    add_ch      = 1'b0;
    add_dg      = 1'b0;
    is_pair     = 1'b0;
    pair_second = 8'h3D;
    pair_short  = TK_ERROR;
    pair_long   = TK_ERROR;

    case (mode_r)
      M_IDENT: begin
        if (is_letter(byte_in) || is_digit(byte_in)) begin
          add_ch = 1'b1;
        end else begin
          has_a = 1'b1;
          if (kw_hit) begin
            tok_a = plain_tok(kw_kind);
          end else begin
            tok_a      = plain_tok(TK_IDENT);
            tok_a.text = text_ext[TEXT_W-1:0];
            tok_a.len  = LEN_W'(cnt_r);
            tok_a.ovf  = ovf_r;
          end
          do_start = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(byte_in)) begin
          add_dg = 1'b1;
        end else begin
          has_a     = 1'b1;
          tok_a     = plain_tok(TK_NUMBER);
          tok_a.num = NUM_W'(acc_r);
          tok_a.ovf = ovf_r;
          do_start  = 1'b1;
        end
      end
      M_LT: begin
        is_pair = 1'b1; pair_short = TK_LT; pair_long = TK_LE;
      end
      M_GT: begin
        is_pair = 1'b1; pair_short = TK_GT; pair_long = TK_GE;
      end
      M_EQ: begin
        is_pair = 1'b1; pair_short = TK_ASSIGN; pair_long = TK_EQ;
      end
      M_PLUS: begin
        is_pair = 1'b1; pair_second = 8'h2B; pair_short = TK_PLUS; pair_long = TK_INC;
      end
      M_MINUS: begin
        is_pair = 1'b1; pair_second = 8'h2D; pair_short = TK_MINUS; pair_long = TK_DEC;
      end
      M_BANG: begin
        is_pair = 1'b1; pair_short = TK_ERROR; pair_long = TK_NE;
      end
      M_SLASH: begin
        if (byte_in == 8'h2A) begin
          mode_nxt = M_COMMENT;
        end else begin
          has_a    = 1'b1;
          tok_a    = plain_tok(TK_SLASH);
          do_start = 1'b1;
        end
      end
      M_COMMENT, M_CSTAR: begin
        if (byte_in == 8'h40) begin
          has_a    = 1'b1;
          tok_a    = plain_tok(TK_ERROR);
          has_b    = 1'b1;
          tok_b    = plain_tok(TK_END);
          mode_nxt = M_IDLE;
        end else if (byte_in == 8'h2A) begin
          mode_nxt = M_CSTAR;
        end else if (byte_in == 8'h2F && mode_r == M_CSTAR) begin
          mode_nxt = M_IDLE;
        end else begin
          mode_nxt = M_COMMENT;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // two-character operators
    if (is_pair) begin
      has_a = 1'b1;
      if (byte_in == pair_second) begin
        tok_a    = plain_tok(pair_long);
        mode_nxt = M_IDLE;
      end else begin
        tok_a    = plain_tok(pair_short);
        do_start = 1'b1;
      end
    end

    // scan the byte as the first of a new token
    if (do_start) begin
      mode_nxt = M_IDLE;
      if (byte_in == 8'h20 || byte_in == 8'h0A) begin
        mode_nxt = M_IDLE;
      end else if (is_letter(byte_in)) begin
        fresh    = 1'b1;
        add_ch   = 1'b1;
        mode_nxt = M_IDENT;
      end else if (is_digit(byte_in)) begin
        fresh    = 1'b1;
        add_dg   = 1'b1;
        mode_nxt = M_NUMBER;
      end else begin
        case (byte_in)
          8'h3C: mode_nxt = M_LT;
          8'h3E: mode_nxt = M_GT;
          8'h3D: mode_nxt = M_EQ;
          8'h2B: mode_nxt = M_PLUS;
          8'h2D: mode_nxt = M_MINUS;
          8'h21: mode_nxt = M_BANG;
          8'h2F: mode_nxt = M_SLASH;
          8'h3A: begin has_b = 1'b1; tok_b = plain_tok(TK_COLON);  end
          8'h3B: begin has_b = 1'b1; tok_b = plain_tok(TK_SEMI);   end
          8'h7B: begin has_b = 1'b1; tok_b = plain_tok(TK_LBRACE); end
          8'h7D: begin has_b = 1'b1; tok_b = plain_tok(TK_RBRACE); end
          8'h28: begin has_b = 1'b1; tok_b = plain_tok(TK_LPAREN); end
          8'h29: begin has_b = 1'b1; tok_b = plain_tok(TK_RPAREN); end
          8'h25: begin has_b = 1'b1; tok_b = plain_tok(TK_PCT);    end
          8'h5B: begin has_b = 1'b1; tok_b = plain_tok(TK_LBRACK); end
          8'h2A: begin has_b = 1'b1; tok_b = plain_tok(TK_STAR);   end
          8'h40: begin has_b = 1'b1; tok_b = plain_tok(TK_END);    end
          default: begin has_b = 1'b1; tok_b = plain_tok(TK_ERROR); end
        endcase
      end
    end

    // identifier and number accumulation, from fresh state on a new token
    base_buf = fresh ? '0 : buf_r;
    base_cnt = fresh ? '0 : cnt_r;
    base_acc = fresh ? '0 : acc_r;
    base_ovf = fresh ? 1'b0 : ovf_r;
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    wide     = {3'b000, base_acc, 1'b0} + {1'b0, base_acc, 3'b000} +
               WIDE_W'(byte_in[3:0]);
    if (add_ch) begin
      buf_nxt = base_buf;
      cnt_nxt = base_cnt;
      ovf_nxt = base_ovf;
      if (base_cnt < CNT_W'(IDENT_CHARS)) begin
        for (int i = 0; i < IDENT_CHARS; i++) begin
          if (base_cnt == CNT_W'(i)) buf_nxt[8*i +: 8] = byte_in;
        end
        cnt_nxt = base_cnt + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (add_dg) begin
      if (base_ovf || wide[WIDE_W-1:NUMBER_WIDTH] != '0) begin
        acc_nxt = '1;
        ovf_nxt = 1'b1;
      end else begin
        acc_nxt = wide[NUMBER_WIDTH-1:0];
        ovf_nxt = 1'b0;
      end
    end

    // pack the tokens from slot 0 and mark the final one
    if (has_b) tok_b.last = 1'b1;
    else       tok_a.last = 1'b1;
    result.count = {1'b0, has_a} + {1'b0, has_b};
    result.tok0  = has_a ? tok_a : tok_b;
    result.tok1  = tok_b;
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      buf_r  <= '0;
      cnt_r  <= '0;
      acc_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

[src/lexical_token_scanner_top.sv]
// lexical_token_scanner_top: byte-in, token-out scanner with a small result queue
// depends on lts_pkg and lts_scan
//
//   channel  direction  payload                                         handshake
//   in_      input      byte_req (8)                                    in_valid / in_ready
//   out_     output     token_kind, number_value, ident_text,           out_valid / out_ready
//                       ident_length, overflow, last
//
// one byte can be accepted every cycle while in_ready is high; with an empty queue its
// first token shows on out_ the cycle after acceptance, a second after the first is taken
// a byte may give zero, one or two tokens; the queue holds four tokens
// in_ready is high while at most two tokens are queued; with out_ready held high a
// two-token byte adds one token of backlog, and a two-token byte that meets two queued
// tokens holds the input until one drains; bytes with no token drain the backlog
// reset (rst_n low, synchronous) empties the queue and returns the scanner to idle
module lexical_token_scanner_top
  import lts_pkg::*;
#(
  parameter int unsigned IDENT_CHARS  = IDENT_CHARS_DEF,
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_token_kind,
  output logic [NUM_W-1:0]  out_number_value,
  output logic [TEXT_W-1:0] out_ident_text,
  output logic [LEN_W-1:0]  out_ident_length,
  output logic              out_overflow,
  output logic              out_last
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  step_t            result;
  logic             in_acc, out_acc;
  tok_t             fifo_r [FIFO_DEPTH];
  tok_t             head;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] push_n;

  assign in_ready  = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_acc   = out_valid && out_ready;

  lts_scan #(
    .IDENT_CHARS  (IDENT_CHARS),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_acc),
    .byte_in (in_byte_req),
    .result  (result)
  );

  // queue pointers and fill count
  always_comb begin
    push_n     = in_acc ? CNT_W'(result.count) : '0;
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(out_acc);
    cnt_nxt    = cnt_r + push_n - CNT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // token storage, up to two writes per item
  always_ff @(posedge clk) begin
    if (in_acc && result.count != 2'd0) fifo_r[wr_ptr_r] <= result.tok0;
    if (in_acc && result.count == 2'd2) fifo_r[wr_ptr_r + PTR_W'(1)] <= result.tok1;
  end

  // head of queue to the ports
  assign head             = fifo_r[rd_ptr_r];
  assign out_token_kind   = head.kind;
  assign out_number_value = head.num;
  assign out_ident_text   = head.text;
  assign out_ident_length = head.len;
  assign out_overflow     = head.ovf;
  assign out_last         = head.last;

endmodule

[src/lts_checker.sv]
// lts_checker: port-level assertions for the lexical token scanner, bound to the top
// depends on lts_pkg and lexical_token_scanner_top
module lts_checker
  import lts_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_token_kind,
  input logic [NUM_W-1:0]  out_number_value,
  input logic [TEXT_W-1:0] out_ident_text,
  input logic [LEN_W-1:0]  out_ident_length,
  input logic              out_overflow,
  input logic              out_last
);

  // a stalled token holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
      $stable(out_number_value) && $stable(out_ident_text) &&
      $stable(out_ident_length) && $stable(out_overflow) && $stable(out_last))
    else $error("stalled token changed");

  // reset empties the queue and opens the input
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("token shown or input blocked right after reset");

  // value field only on number tokens
  a_num_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != TK_NUMBER |-> out_number_value == '0)
    else $error("number value on a non-number token");

  // text and length only on identifier tokens
  a_text_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != TK_IDENT |-> out_ident_text == '0 &&
      out_ident_length == '0)
    else $error("identifier text on a non-identifier token");

  // overflow only on identifiers and numbers
  a_ovf_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_token_kind == TK_IDENT ||
      out_token_kind == TK_NUMBER)
    else $error("overflow flag on an operator or keyword token");

endmodule

bind lexical_token_scanner_top lts_checker u_lts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_token_kind   (out_token_kind),
  .out_number_value (out_number_value),
  .out_ident_text   (out_ident_text),
  .out_ident_length (out_ident_length),
  .out_overflow     (out_overflow),
  .out_last         (out_last)
);

[test/lts_token_checker.sv]
// lts_token_checker: watches both channels of the lexical token scanner, predicts tokens
// from the accepted bytes and compares them; depends on lts_pkg
`timescale 1ns / 1ps

module lts_token_checker
  import lts_pkg::*;
#(
  parameter int unsigned IDENT_CHARS  = IDENT_CHARS_DEF,
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_byte_req,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [KIND_W-1:0] out_token_kind,
  input  logic [NUM_W-1:0]  out_number_value,
  input  logic [TEXT_W-1:0] out_ident_text,
  input  logic [LEN_W-1:0]  out_ident_length,
  input  logic              out_overflow,
  input  logic              out_last,
  output int                fail_count,
  output int                tokens_pending
);

  localparam logic [7:0]  NEWLINE   = 8'h0A;
  localparam int unsigned MAX_TOKS  = 2;
  localparam logic [63:0] NUM_LIMIT = (NUMBER_WIDTH >= 64) ? '1 :
                                      ((64'd1 << NUMBER_WIDTH) - 64'd1);

  string keyword_text [6] = '{"if", "else", "while", "do", "for", "switch"};
  kind_t keyword_kind [6] = '{TK_IF, TK_ELSE, TK_WHILE, TK_DO, TK_FOR, TK_SWITCH};

  // scanner state mirrored from the accepted bytes
  mode_t       scan_state;
  logic [63:0] ident_buf;
  int unsigned ident_cnt;
  logic [63:0] num_acc;
  logic        ovf_seen;
  int unsigned step_emitted;

  tok_t expected_tokens [$];
  int   fails;
  int   token_index;

  initial begin
    fails       = 0;
    token_index = 0;
  end

  function automatic logic letter_byte(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic clear_scanner();
    scan_state = M_IDLE;
    ident_buf  = '0;
    ident_cnt  = 0;
    num_acc    = '0;
    ovf_seen   = 1'b0;
  endtask

  task automatic push_token(kind_t k, logic [63:0] num, logic [63:0] text,
                            int unsigned len, logic ovf);
    tok_t t;
    if (step_emitted >= MAX_TOKS) return;
    t      = '0;
    t.kind = k;
    t.num  = num[NUM_W-1:0];
    t.text = text[TEXT_W-1:0];
    t.len  = len[LEN_W-1:0];
    t.ovf  = ovf;
    expected_tokens.push_back(t);
    step_emitted++;
  endtask

  task automatic append_char(logic [7:0] c);
    if (ident_cnt < IDENT_CHARS && ident_cnt < 8) begin
      ident_buf[8*ident_cnt +: 8] = c;
      ident_cnt++;
    end else begin
      ovf_seen = 1'b1;
    end
  endtask

  // decimal accumulate with saturation at the number width
  task automatic append_digit(logic [7:0] c);
    logic [63:0] d;
    d = {56'd0, c} - {56'd0, 8'("0")};
    if (ovf_seen || num_acc > (NUM_LIMIT - d) / 64'd10) begin
      num_acc  = NUM_LIMIT;
      ovf_seen = 1'b1;
    end else begin
      num_acc = num_acc * 64'd10 + d;
    end
  endtask

  // keyword lookup, skipped for truncated identifiers
  task automatic close_ident();
    string kw;
    logic  same;
    if (!ovf_seen) begin
      for (int k = 0; k < 6; k++) begin
        kw = keyword_text[k];
        if (kw.len() == ident_cnt) begin
          same = 1'b1;
          for (int i = 0; i < kw.len(); i++)
            if (ident_buf[8*i +: 8] != kw[i]) same = 1'b0;
          if (same) begin
            push_token(keyword_kind[k], 0, 0, 0, 1'b0);
            return;
          end
        end
      end
    end
    push_token(TK_IDENT, 0, ident_buf, ident_cnt, ovf_seen);
  endtask

  // byte seen from idle
  task automatic open_token(logic [7:0] c);
    scan_state = M_IDLE;
    if (c == " " || c == NEWLINE) return;
    if (letter_byte(c)) begin
      ident_buf = '0;
      ident_cnt = 0;
      ovf_seen  = 1'b0;
      append_char(c);
      scan_state = M_IDENT;
      return;
    end
    if (digit_byte(c)) begin
      num_acc  = '0;
      ovf_seen = 1'b0;
      append_digit(c);
      scan_state = M_NUMBER;
      return;
    end
    case (c)
      "<": scan_state = M_LT;
      ">": scan_state = M_GT;
      "=": scan_state = M_EQ;
      "+": scan_state = M_PLUS;
      "-": scan_state = M_MINUS;
      "!": scan_state = M_BANG;
      "/": scan_state = M_SLASH;
      ":": push_token(TK_COLON, 0, 0, 0, 1'b0);
      ";": push_token(TK_SEMI, 0, 0, 0, 1'b0);
      "{": push_token(TK_LBRACE, 0, 0, 0, 1'b0);
      "}": push_token(TK_RBRACE, 0, 0, 0, 1'b0);
      "(": push_token(TK_LPAREN, 0, 0, 0, 1'b0);
      ")": push_token(TK_RPAREN, 0, 0, 0, 1'b0);
      "%": push_token(TK_PCT, 0, 0, 0, 1'b0);
      "[": push_token(TK_LBRACK, 0, 0, 0, 1'b0);
      "*": push_token(TK_STAR, 0, 0, 0, 1'b0);
      "@": push_token(TK_END, 0, 0, 0, 1'b0);
      default: push_token(TK_ERROR, 0, 0, 0, 1'b0);
    endcase
  endtask

  // two-character operators: long form on a match, else short form and rescan
  task automatic pair_op(logic [7:0] c, logic [7:0] second, kind_t k_short, kind_t k_long);
    if (c == second) begin
      push_token(k_long, 0, 0, 0, 1'b0);
      scan_state = M_IDLE;
    end else begin
      push_token(k_short, 0, 0, 0, 1'b0);
      open_token(c);
    end
  endtask

  task automatic scan_byte(logic [7:0] c);
    tok_t t;
    step_emitted = 0;
    case (scan_state)
      M_IDENT: begin
        if (letter_byte(c) || digit_byte(c)) append_char(c);
        else begin
          close_ident();
          open_token(c);
        end
      end
      M_NUMBER: begin
        if (digit_byte(c)) append_digit(c);
        else begin
          push_token(TK_NUMBER, num_acc, 0, 0, ovf_seen);
          open_token(c);
        end
      end
      M_LT:    pair_op(c, "=", TK_LT, TK_LE);
      M_GT:    pair_op(c, "=", TK_GT, TK_GE);
      M_EQ:    pair_op(c, "=", TK_ASSIGN, TK_EQ);
      M_PLUS:  pair_op(c, "+", TK_PLUS, TK_INC);
      M_MINUS: pair_op(c, "-", TK_MINUS, TK_DEC);
      M_BANG:  pair_op(c, "=", TK_ERROR, TK_NE);
      M_SLASH: begin
        if (c == "*") scan_state = M_COMMENT;
        else begin
          push_token(TK_SLASH, 0, 0, 0, 1'b0);
          open_token(c);
        end
      end
      M_COMMENT, M_CSTAR: begin
        // end of input inside a comment gives an error then the end token
        if (c == "@") begin
          push_token(TK_ERROR, 0, 0, 0, 1'b0);
          push_token(TK_END, 0, 0, 0, 1'b0);
          scan_state = M_IDLE;
        end else if (c == "*") begin
          scan_state = M_CSTAR;
        end else if (c == "/" && scan_state == M_CSTAR) begin
          scan_state = M_IDLE;
        end else begin
          scan_state = M_COMMENT;
        end
      end
      default: open_token(c);
    endcase
    // flag the final token of this byte
    if (step_emitted > 0) begin
      t      = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  function automatic int field_bad(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: token %0d %s mismatch: expected %0h, actual %0h",
               $time, token_index, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // compare first, then predict, so a stray token never meets a fresh expectation
  always @(posedge clk) begin : watch
    tok_t want;
    int   bad;
    if (!rst_n) begin
      clear_scanner();
      expected_tokens.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token: expected none, actual kind %0d",
                   $time, out_token_kind);
          fails++;
        end else begin
          want = expected_tokens.pop_front();
          bad  = field_bad("token_kind", want.kind, out_token_kind)
               + field_bad("number_value", want.num, out_number_value)
               + field_bad("ident_text", want.text, out_ident_text)
               + field_bad("ident_length", want.len, out_ident_length)
               + field_bad("overflow", want.ovf, out_overflow)
               + field_bad("last", want.last, out_last);
          if (bad != 0) fails++;
        end
        token_index++;
      end
      if (in_valid && in_ready) scan_byte(in_byte_req);
    end
    fail_count     <= fails;
    tokens_pending <= expected_tokens.size();
  end

endmodule

[test/tb_lexical_token_scanner_top.sv]
// tb_lexical_token_scanner_top: clock, reset, byte stimulus, receiver stalls and verdict
// depends on lts_pkg, lexical_token_scanner_top and lts_token_checker
`timescale 1ns / 1ps

module tb_lexical_token_scanner_top
  import lts_pkg::*;
();

  localparam int unsigned RANDOM_BYTES = 550;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [7:0]  NEWLINE      = 8'h0A;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [7:0]        in_byte_req = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [KIND_W-1:0] out_token_kind;
  logic [NUM_W-1:0]  out_number_value;
  logic [TEXT_W-1:0] out_ident_text;
  logic [LEN_W-1:0]  out_ident_length;
  logic              out_overflow;
  logic              out_last;
  int                fail_count;
  int                tokens_pending;

  string keyword_text [6]  = '{"if", "else", "while", "do", "for", "switch"};
  string op_text [22]      = '{"<", "<=", ">", ">=", "=", "==", "+", "++", "-", "--", "!=",
                               "!", ":", ";", "{", "}", "(", ")", "%", "[", "*", "/"};

  logic [7:0]  source_bytes [$];
  int          hold_ask  = 0;
  int          hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_window = 0;
  int unsigned rx_pct    = 100;
  int unsigned quiet     = 0;

  always #4 clk = ~clk;

  lexical_token_scanner_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_req      (in_byte_req),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_ident_text   (out_ident_text),
    .out_ident_length (out_ident_length),
    .out_overflow     (out_overflow),
    .out_last         (out_last)
  );

  lts_token_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_req      (in_byte_req),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_ident_text   (out_ident_text),
    .out_ident_length (out_ident_length),
    .out_overflow     (out_overflow),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .tokens_pending   (tokens_pending)
  );

  function automatic logic [7:0] random_letter();
    if ($urandom_range(0, 1) == 0) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) source_bytes.push_back(s[i]);
  endtask

  // one random lexeme, mostly well formed, followed by an optional separator
  task automatic add_lexeme();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      add_text(keyword_text[$urandom_range(0, 5)]);
    end else if (pick < 26) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 7);
      source_bytes.push_back(random_letter());
      for (int i = 1; i < len; i++)
        source_bytes.push_back(($urandom_range(0, 2) == 0) ? random_digit() : random_letter());
    end else if (pick < 38) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) source_bytes.push_back(random_digit());
    end else if (pick < 62) begin
      add_text(op_text[$urandom_range(0, 21)]);
    end else if (pick < 70) begin
      // comment with random body and a run of stars before the closing slash
      add_text("/*");
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0: c = random_letter();
          1: c = "*";
          2: c = " ";
          default: c = 8'($urandom_range(0, 255));
        endcase
        if (c == "@") c = "x";
        source_bytes.push_back(c);
      end
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) source_bytes.push_back("*");
      source_bytes.push_back("/");
    end else if (pick < 73) begin
      add_text("/*");
      if ($urandom_range(0, 1) == 0) source_bytes.push_back("*");
      source_bytes.push_back("@");
    end else if (pick < 77) begin
      source_bytes.push_back("@");
    end else begin
      source_bytes.push_back(8'($urandom_range(0, 255)));
    end
    pick = $urandom_range(0, 99);
    if (pick < 35) source_bytes.push_back(" ");
    else if (pick < 50) source_bytes.push_back(NEWLINE);
  endtask

  // receiver: random ready pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_window == 0) begin
        rx_window <= $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: rx_pct <= 100;
          1: rx_pct <= 90;
          2: rx_pct <= 50;
          default: rx_pct <= 25;
        endcase
      end else begin
        rx_window <= rx_window - 1;
      end
      out_ready <= ($urandom_range(1, 100) <= rx_pct);
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned directed_len;
    int unsigned hold_at;
    int unsigned pause_at;
    int unsigned burst_left;

    // directed: truncated identifier, saturated number, lone bang, comments, end handling
    add_text("abcdefgh 5000000000!x/**/@/*@");
    directed_len = source_bytes.size();
    while (source_bytes.size() < directed_len + RANDOM_BYTES) add_lexeme();
    hold_at  = directed_len + 150;
    pause_at = directed_len + 350;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = $urandom_range(1, 12);
    for (int unsigned idx = 0; idx < source_bytes.size(); idx++) begin
      if (idx == hold_at) hold_ask <= hold_ask + 1;
      // let every expected token drain before going on
      if (idx == pause_at) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (tokens_pending != 0);
      end
      in_valid    <= 1'b1;
      in_byte_req <= source_bytes[idx];
      do @(posedge clk); while (!in_ready);
      burst_left--;
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (tokens_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
